[hdl/nfs_pkg.sv]
// Shared types and constants for the NEH flow-shop sequencer.
// Used by nfs_alu, nfs_ctrl, the top level and nfs_checker; depends on nothing.
`default_nettype none
package nfs_pkg;

  localparam int DEF_MAX_JOBS     = 32;
  localparam int DEF_MAX_MACHINES = 16;
  localparam int DEF_TIME_BITS    = 16;

  localparam int JOB_W  = 5;   // seq_job, job_index port width
  localparam int MACH_W = 4;   // machine_index port width
  localparam int POS_W  = 5;
  localparam int MS_W   = 26;
  localparam int TOT_W  = 21;
  localparam int CFGI_W = 2;
  localparam int CFGD_W = 8;
  localparam int JCNT_W = 6;
  localparam int MCNT_W = 5;

  localparam logic [CFGI_W-1:0] REG_JOB_COUNT  = 2'd0;
  localparam logic [CFGI_W-1:0] REG_MACH_COUNT = 2'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TOT_RD,
    S_TOT_AC,
    S_SRT,
    S_NEH_JOB,
    S_EV_START,
    S_EV_RD,
    S_EV_AC,
    S_EV_DONE,
    S_INS,
    S_OUT
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [POS_W-1:0]  pos;
    logic [JOB_W-1:0]  job;
    logic [MS_W-1:0]   ms;
    logic              last;
  } res_t;

endpackage
`default_nettype wire

[hdl/nfs_tmem.sv]
// Processing-time matrix store: one write port, one registered read port.
// Depends on nothing but its parameters.
`default_nettype none
module nfs_tmem #(
  parameter int AW = 9,
  parameter int DW = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hdl/nfs_alu.sv]
// Shared step unit: saturating max(a, b) + t, used for row sums and makespan.
// Depends on nfs_pkg.
`default_nettype none
module nfs_alu #(
  parameter int TIME_BITS = nfs_pkg::DEF_TIME_BITS
) (
  input  wire logic [nfs_pkg::MS_W-1:0] a,
  input  wire logic [nfs_pkg::MS_W-1:0] b,
  input  wire logic [TIME_BITS-1:0]     t,
  output logic      [nfs_pkg::MS_W-1:0] y
);
  import nfs_pkg::*;

  localparam int SW = ((MS_W > TIME_BITS) ? MS_W : TIME_BITS) + 1;
  localparam logic [SW-1:0] SAT = SW'({MS_W{1'b1}});

  logic [MS_W-1:0] mx;
  logic [SW-1:0]   sum;

  always_comb begin
    mx  = (a > b) ? a : b;
    sum = SW'(mx) + SW'(t);
    y   = (sum > SAT) ? '1 : sum[MS_W-1:0];
  end

endmodule
`default_nettype wire

[hdl/nfs_ctrl.sv]
// Sequencer for the NEH heuristic: row sums, insertion sort, trial insertion
// with makespan evaluation on the shared step unit, and result output.
// Depends on nfs_pkg and nfs_alu; reads the matrix through nfs_tmem.
`default_nettype none
module nfs_ctrl #(
  parameter int MAX_JOBS     = nfs_pkg::DEF_MAX_JOBS,
  parameter int MAX_MACHINES = nfs_pkg::DEF_MAX_MACHINES,
  parameter int TIME_BITS    = nfs_pkg::DEF_TIME_BITS,
  parameter int JIW          = nfs_pkg::JOB_W,
  parameter int MIW          = nfs_pkg::MACH_W
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        go,
  input  wire logic [nfs_pkg::JCNT_W-1:0]  job_count,
  input  wire logic [nfs_pkg::MCNT_W-1:0]  machine_count,
  output logic      [JIW+MIW-1:0]          raddr,
  input  wire logic [TIME_BITS-1:0]        rdata,
  output logic                             busy,
  output nfs_pkg::res_t                    res
);
  import nfs_pkg::*;

  localparam int CW  = $clog2(MAX_JOBS + 1);
  localparam int MCW = $clog2(MAX_MACHINES + 1);

  state_t state_r, state_nxt;

  logic [CW-1:0]   nj_r, nj_nxt, i_r, i_nxt, k_r, k_nxt, len_r, len_nxt;
  logic [CW-1:0]   p_r, p_nxt, q_r, q_nxt, o_r, o_nxt, best_pos_r, best_pos_nxt;
  logic [MCW-1:0]  mc_r, mc_nxt, j_r, j_nxt;
  logic [MS_W-1:0] acc_r, acc_nxt, left_r, left_nxt, best_r, best_nxt;
  logic [MS_W-1:0] cand_ms_r, cand_ms_nxt, ms_r, ms_nxt;
  logic [TOT_W-1:0] tot_i_r, tot_i_nxt;
  logic [JIW-1:0]  job_r, job_nxt;
  logic            final_r, final_nxt;

  logic [MS_W-1:0]  crow_r [MAX_MACHINES];
  logic [TOT_W-1:0] jtot_r [MAX_JOBS];
  logic [JIW-1:0]   sorted_r [MAX_JOBS];
  logic [JIW-1:0]   part_r [MAX_JOBS];

  logic            crow_clr, crow_we;
  logic            jtot_we, sort_we, part_we;
  logic [JIW-1:0]  sort_waddr, sort_wdata, sort_raddr, sort_rd;
  logic [JIW-1:0]  part_waddr, part_wdata, part_raddr, part_rd;
  logic [MS_W-1:0] alu_a, alu_b, alu_y;
  logic [CW-1:0]   k_m1, q_last, cand_idx;
  logic [JIW-1:0]  cand_job;
  logic            j_last, goes_before, ms_lt;
  logic [TOT_W-1:0] cmp_tot;

  nfs_alu #(.TIME_BITS(TIME_BITS)) u_alu (
    .a (alu_a),
    .b (alu_b),
    .t (rdata),
    .y (alu_y)
  );

  always_comb begin
    k_m1     = k_r - CW'(1);
    j_last   = (j_r == mc_r - MCW'(1));
    q_last   = final_r ? (len_r - CW'(1)) : len_r;
    sort_raddr = (state_r == S_NEH_JOB) ? i_r[JIW-1:0] : k_m1[JIW-1:0];
    sort_rd  = sorted_r[sort_raddr];
    cmp_tot  = jtot_r[sort_rd];
    goes_before = (tot_i_r > cmp_tot) || ((tot_i_r == cmp_tot) && (i_r > CW'(sort_rd)));
    // Trial sequence: the new job sits at position p, later jobs move one up.
    if (final_r || (q_r < p_r)) begin
      cand_idx = q_r;
    end else begin
      cand_idx = q_r - CW'(1);
    end
    case (state_r)
      S_INS:   part_raddr = k_m1[JIW-1:0];
      S_OUT:   part_raddr = o_r[JIW-1:0];
      default: part_raddr = cand_idx[JIW-1:0];
    endcase
    part_rd  = part_r[part_raddr];
    cand_job = (!final_r && (q_r == p_r)) ? job_r : part_rd;
    ms_lt    = (cand_ms_r < best_r);
  end

  always_comb begin
    raddr = '0;
    alu_a = acc_r;
    alu_b = '0;
    case (state_r)
      S_TOT_RD: raddr = {i_r[JIW-1:0], j_r[MIW-1:0]};
      S_EV_RD:  raddr = {cand_job, j_r[MIW-1:0]};
      S_EV_AC: begin
        alu_a = crow_r[j_r[MIW-1:0]];
        alu_b = left_r;
      end
      default: begin
        raddr = '0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (go) state_nxt = S_TOT_RD;
      S_TOT_RD:   state_nxt = S_TOT_AC;
      S_TOT_AC:   state_nxt = j_last ? S_SRT : S_TOT_RD;
      S_SRT: begin
        if (!((k_r != '0) && goes_before)) begin
          state_nxt = (i_r == nj_r - CW'(1)) ? S_NEH_JOB : S_TOT_RD;
        end
      end
      S_NEH_JOB:  state_nxt = S_EV_START;
      S_EV_START: state_nxt = S_EV_RD;
      S_EV_RD:    state_nxt = S_EV_AC;
      S_EV_AC:    state_nxt = (j_last && (q_r == q_last)) ? S_EV_DONE : S_EV_RD;
      S_EV_DONE: begin
        if (final_r) begin
          state_nxt = S_OUT;
        end else if (p_r == len_r) begin
          state_nxt = S_INS;
        end else begin
          state_nxt = S_EV_START;
        end
      end
      S_INS: begin
        if (!(k_r > best_pos_r)) begin
          state_nxt = (i_r == nj_r - CW'(1)) ? S_EV_START : S_NEH_JOB;
        end
      end
      S_OUT:      if (o_r == nj_r - CW'(1)) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Datapath updates.
  always_comb begin
    nj_nxt = nj_r;  mc_nxt = mc_r;  i_nxt = i_r;  k_nxt = k_r;  len_nxt = len_r;
    p_nxt = p_r;  q_nxt = q_r;  o_nxt = o_r;  best_pos_nxt = best_pos_r;  j_nxt = j_r;
    acc_nxt = acc_r;  left_nxt = left_r;  best_nxt = best_r;  cand_ms_nxt = cand_ms_r;
    ms_nxt = ms_r;  tot_i_nxt = tot_i_r;  job_nxt = job_r;  final_nxt = final_r;
    crow_clr = 1'b0;  crow_we = 1'b0;  jtot_we = 1'b0;
    sort_we = 1'b0;  sort_waddr = k_r[JIW-1:0];  sort_wdata = i_r[JIW-1:0];
    part_we = 1'b0;  part_waddr = k_r[JIW-1:0];  part_wdata = job_r;
    case (state_r)
      S_IDLE: begin
        if (go) begin
          if (job_count == '0) begin
            nj_nxt = CW'(1);
          end else if (int'(job_count) > MAX_JOBS) begin
            nj_nxt = CW'(MAX_JOBS);
          end else begin
            nj_nxt = CW'(job_count);
          end
          if (machine_count == '0) begin
            mc_nxt = MCW'(1);
          end else if (int'(machine_count) > MAX_MACHINES) begin
            mc_nxt = MCW'(MAX_MACHINES);
          end else begin
            mc_nxt = MCW'(machine_count);
          end
          i_nxt = '0;  j_nxt = '0;  acc_nxt = '0;  final_nxt = 1'b0;
        end
      end
      S_TOT_AC: begin
        acc_nxt = alu_y;
        if (j_last) begin
          jtot_we   = 1'b1;
          tot_i_nxt = alu_y[TOT_W-1:0];
          k_nxt     = i_r;
        end else begin
          j_nxt = j_r + MCW'(1);
        end
      end
      S_SRT: begin
        sort_we = 1'b1;
        if ((k_r != '0) && goes_before) begin
          sort_wdata = sort_rd;
          k_nxt      = k_m1;
        end else if (i_r == nj_r - CW'(1)) begin
          i_nxt = '0;  len_nxt = '0;
        end else begin
          i_nxt = i_r + CW'(1);  j_nxt = '0;  acc_nxt = '0;
        end
      end
      S_NEH_JOB: begin
        job_nxt = sort_rd;  best_nxt = '1;  best_pos_nxt = '0;  p_nxt = '0;
      end
      S_EV_START: begin
        crow_clr = 1'b1;  q_nxt = '0;  j_nxt = '0;  left_nxt = '0;
      end
      S_EV_AC: begin
        crow_we = 1'b1;
        if (j_last) begin
          j_nxt = '0;  left_nxt = '0;  cand_ms_nxt = alu_y;
          q_nxt = q_r + CW'(1);
        end else begin
          j_nxt = j_r + MCW'(1);  left_nxt = alu_y;
        end
      end
      S_EV_DONE: begin
        if (final_r) begin
          ms_nxt = cand_ms_r;  o_nxt = '0;
        end else begin
          if (ms_lt) begin
            best_nxt = cand_ms_r;  best_pos_nxt = p_r;
          end
          p_nxt = p_r + CW'(1);
          k_nxt = len_r;
        end
      end
      S_INS: begin
        part_we = 1'b1;
        if (k_r > best_pos_r) begin
          part_wdata = part_rd;
          k_nxt      = k_m1;
        end else begin
          len_nxt = len_r + CW'(1);
          if (i_r == nj_r - CW'(1)) begin
            final_nxt = 1'b1;
          end else begin
            i_nxt = i_r + CW'(1);
          end
        end
      end
      S_OUT: o_nxt = o_r + CW'(1);
      default: begin
        crow_clr = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nj_r <= nj_nxt;  mc_r <= mc_nxt;  i_r <= i_nxt;  k_r <= k_nxt;  len_r <= len_nxt;
    p_r <= p_nxt;  q_r <= q_nxt;  o_r <= o_nxt;  best_pos_r <= best_pos_nxt;
    j_r <= j_nxt;  acc_r <= acc_nxt;  left_r <= left_nxt;  best_r <= best_nxt;
    cand_ms_r <= cand_ms_nxt;  ms_r <= ms_nxt;  tot_i_r <= tot_i_nxt;
    job_r <= job_nxt;  final_r <= final_nxt;
    if (jtot_we) jtot_r[i_r[JIW-1:0]] <= tot_i_nxt;
    if (sort_we) sorted_r[sort_waddr] <= sort_wdata;
    if (part_we) part_r[part_waddr] <= part_wdata;
    for (int m = 0; m < MAX_MACHINES; m++) begin
      if (crow_clr) begin
        crow_r[m] <= '0;
      end else if (crow_we && (j_r[MIW-1:0] == MIW'(m))) begin
        crow_r[m] <= alu_y;
      end
    end
  end

  always_comb begin
    busy       = (state_r != S_IDLE);
    res.valid  = (state_r == S_OUT);
    res.pos    = POS_W'(o_r);
    res.job    = JOB_W'(part_rd);
    res.ms     = ms_r;
    res.last   = (o_r == nj_r - CW'(1));
  end

endmodule
`default_nettype wire

[hdl/neh_flow_shop_sequencer.sv]
// NEH flow-shop sequencer top level. Matrix entries load one per cycle while not busy.
// An entry flagged last starts NEH: a row sum and an insertion-sort pass per job,
// then a makespan evaluation per trial position against the partial sequence,
// and finally J results, one per cycle, with no stall.
// Synchronous active-low reset returns to idle and sets both counts to 1.
// Depends on nfs_pkg, nfs_tmem, nfs_alu and nfs_ctrl.
`default_nettype none
module neh_flow_shop_sequencer #(
  parameter int MAX_JOBS     = nfs_pkg::DEF_MAX_JOBS,
  parameter int MAX_MACHINES = nfs_pkg::DEF_MAX_MACHINES,
  parameter int TIME_BITS    = nfs_pkg::DEF_TIME_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [nfs_pkg::JOB_W-1:0]   in_job_index,
  input  wire logic [nfs_pkg::MACH_W-1:0]  in_machine_index,
  input  wire logic [15:0]                 in_proc_time,
  input  wire logic                        in_last_entry,
  output logic                             out_valid,
  output logic [nfs_pkg::POS_W-1:0]        out_seq_position,
  output logic [nfs_pkg::JOB_W-1:0]        out_seq_job,
  output logic [nfs_pkg::MS_W-1:0]         out_makespan,
  output logic                             out_last_result,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [nfs_pkg::CFGI_W-1:0]  cfg_index,
  input  wire logic [nfs_pkg::CFGD_W-1:0]  cfg_data
);
  import nfs_pkg::*;

  localparam int JIW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int MIW = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;

  logic [JCNT_W-1:0]  job_count_r;
  logic [MCNT_W-1:0]  machine_count_r;
  logic               accept, go, wr_en;
  logic [JIW+MIW-1:0] raddr;
  logic [TIME_BITS-1:0] rdata;
  res_t               res;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign go        = accept && in_last_entry;
  assign wr_en     = accept && (int'(in_job_index) < MAX_JOBS)
                     && (int'(in_machine_index) < MAX_MACHINES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_count_r     <= JCNT_W'(1);
      machine_count_r <= MCNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_JOB_COUNT) job_count_r <= cfg_data[JCNT_W-1:0];
      if (cfg_index == REG_MACH_COUNT) machine_count_r <= cfg_data[MCNT_W-1:0];
    end
  end

  nfs_tmem #(.AW(JIW + MIW), .DW(TIME_BITS)) u_tmem (
    .clk   (clk),
    .we    (wr_en),
    .waddr ({JIW'(in_job_index), MIW'(in_machine_index)}),
    .wdata (TIME_BITS'(in_proc_time)),
    .raddr (raddr),
    .rdata (rdata)
  );

  nfs_ctrl #(
    .MAX_JOBS     (MAX_JOBS),
    .MAX_MACHINES (MAX_MACHINES),
    .TIME_BITS    (TIME_BITS),
    .JIW          (JIW),
    .MIW          (MIW)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .go            (go),
    .job_count     (job_count_r),
    .machine_count (machine_count_r),
    .raddr         (raddr),
    .rdata         (rdata),
    .busy          (busy),
    .res           (res)
  );

  assign out_valid        = res.valid;
  assign out_seq_position = res.pos;
  assign out_seq_job      = res.job;
  assign out_makespan     = res.ms;
  assign out_last_result  = res.last;

endmodule
`default_nettype wire

[hdl/nfs_checker.sv]
// Port-level checks for the NEH flow-shop sequencer, bound to the top level.
// Depends on nfs_pkg for port widths.
`default_nettype none
module nfs_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        busy,
  input wire logic                        out_valid,
  input wire logic [nfs_pkg::POS_W-1:0]   out_seq_position,
  input wire logic [nfs_pkg::MS_W-1:0]    out_makespan,
  input wire logic                        out_last_result
);

  // A result word only appears while a sequencing run is in progress.
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result word while idle");

  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_result |=> out_valid) else $error("result burst broken");

  a_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_result |=> out_seq_position == $past(out_seq_position) + 1'b1)
    else $error("positions not consecutive");

  a_ms: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_result |=> $stable(out_makespan)) else $error("makespan changed");

  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_result |=> !busy) else $error("busy after final word");

endmodule

bind neh_flow_shop_sequencer nfs_checker u_nfs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_seq_position (out_seq_position),
  .out_makespan     (out_makespan),
  .out_last_result  (out_last_result)
);
`default_nettype wire
